### rtl/lzd_pkg.sv
// Shared types and constants for the LZ byte stream decompressor.
// No dependencies; every other file except lzd_stream_if imports this package.
`default_nettype none

package lzd_pkg;

  localparam int HISTORY_BITS = 16;
  localparam int HIST_SIZE    = 1 << HISTORY_BITS;
  localparam int CNT_BITS     = HISTORY_BITS + 1;
  localparam int MAX_MATCH    = 31;
  localparam int LEN_BITS     = $clog2(MAX_MATCH + 1);

  // token classification of a lead byte
  localparam logic [1:0] LEAD_TAG = 2'd3;
  localparam logic [2:0] SHORT_ID = 3'd6;
  localparam logic [2:0] LONG_ID  = 3'd7;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ST_OK,
    ST_TRUNC,
    ST_BAD
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_DIST_LO
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EMIT,
    B_MRD,
    B_MWR
  } back_state_t;

  // work for one accepted input word: up to two literals, one copy, a status
  typedef struct packed {
    logic                    lit0_v;
    logic [7:0]              lit0;
    logic                    lit1_v;
    logic [7:0]              lit1;
    logic                    match_v;
    logic [LEN_BITS-1:0]     len;
    logic [HISTORY_BITS-1:0] distance;
    logic                    done;
    status_t                 status;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/lzd_stream_if.sv
// Valid/ready channel interfaces for compressed input and decompressed output.
// No dependencies.
`default_nettype none

interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       run_last;
  logic       stream_done;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_present, output run_last,
                  output stream_done, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_present, input run_last,
                  input stream_done, input status, output ready);
endinterface

`default_nettype wire

### rtl/lz_byte_stream_decompressor.sv
// Top level of the LZ byte stream decompressor: parser, command queue, copy engine.
// Depends on lzd_pkg, lzd_stream_if, lzd_front, lzd_cmd_fifo and lzd_back.
//
// Usage:
//   in_chan carries one compressed byte per word plus end_of_input on the final
//   byte of a stream. out_chan carries result words: decompressed bytes
//   (byte_present 1) and, after the final input, one status word (stream_done 1,
//   status 0 ok / 1 truncated / 2 bad distance or length). run_last marks the
//   last result word caused by one input word; an input that causes nothing
//   (a held lead byte, a distance byte, bytes after an error) produces no word.
//   Flow: an input word is parsed in the cycle it is accepted and queued. The
//   copy engine picks up a queued command from its idle state, emits each
//   literal or status word from its emit state, passes through that state to
//   start a match, and copies each match byte through a history read state and
//   then a write-and-emit state; the history memory's single registered read
//   port sets this.
//   The parser runs ahead through a four-entry queue, so input keeps flowing
//   while the engine expands a match, and the output register lets the engine
//   load the next word while the receiver takes the current one.
//   Reset (rst, synchronous) clears the parser, queue, write pointer and output
//   valid. History is never cleared; only bytes written in the current stream
//   are ever read. When out_chan.ready is low the engine holds, the queue fills
//   and in_chan.ready drops.
`default_nettype none

module lz_byte_stream_decompressor
  import lzd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lzd_in_if.sink    in_chan,
  lzd_out_if.source out_chan
);

  // parser -> queue
  logic push;
  cmd_t push_data;
  logic fifo_full;

  // queue -> engine
  logic pop;
  cmd_t head;
  logic fifo_empty;

  lzd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_chan),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  lzd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  lzd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

### rtl/lzd_front.sv
// Token parser: accepts compressed words, tracks stream state, checks matches.
// Depends on lzd_pkg and lzd_stream_if.
`default_nettype none

module lzd_front
  import lzd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lzd_in_if.sink    in_chan,
  input  wire logic fifo_full,
  output logic      push,
  output cmd_t      push_data
);

  phase_t              phase, phase_next;
  logic [7:0]          held_lead, held_lead_next;
  logic [7:0]          held_dhi, held_dhi_next;
  status_t             err, err_next;
  logic [CNT_BITS-1:0] bw, bw_next;
  cmd_t                cmd;
  logic                accept;

  assign in_chan.ready = !fifo_full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    logic [7:0]              b;
    logic [HISTORY_BITS-1:0] distance;
    logic [LEN_BITS-1:0]     len;
    logic                    try_match;
    logic [CNT_BITS:0]       sum;
    logic [1:0]              nlits;
    b              = in_chan.in_byte;
    len            = held_lead[LEN_BITS-1:0];
    distance       = '0;
    try_match      = 1'b0;
    phase_next     = phase;
    held_lead_next = held_lead;
    held_dhi_next  = held_dhi;
    err_next       = err;
    cmd            = '0;
    cmd.status     = ST_OK;

    if (err == ST_OK) begin
      phase_next = PH_IDLE;
      unique case (phase)
        PH_DIST_LO: begin
          try_match = 1'b1;
          distance  = {held_dhi, b};
        end
        PH_LEAD: begin
          if (held_lead[7:5] == LONG_ID && in_chan.end_of_input) begin
            err_next = ST_TRUNC;
          end else if (b[7]) begin
            // held lead was a plain byte; reparse this one
            cmd.lit0_v = 1'b1;
            cmd.lit0   = held_lead;
            if (b[7:6] != LEAD_TAG) begin
              cmd.lit1_v = 1'b1;
              cmd.lit1   = b;
            end else if (in_chan.end_of_input) begin
              err_next = ST_TRUNC;
            end else begin
              held_lead_next = b;
              phase_next     = PH_LEAD;
            end
          end else if (held_lead[7:5] == SHORT_ID) begin
            try_match = 1'b1;
            distance  = {8'd0, b};
          end else begin
            held_dhi_next = b;
            phase_next    = PH_DIST_LO;
          end
        end
        default: begin
          if (b[7:6] != LEAD_TAG) begin
            cmd.lit1_v = 1'b1;
            cmd.lit1   = b;
          end else if (in_chan.end_of_input) begin
            err_next = ST_TRUNC;
          end else begin
            held_lead_next = b;
            phase_next     = PH_LEAD;
          end
        end
      endcase
    end

    if (try_match) begin
      if (distance == '0 || {1'b0, distance} > bw || len == '0) begin
        err_next = ST_BAD;
      end else begin
        cmd.match_v  = 1'b1;
        cmd.len      = len;
        cmd.distance = distance;
      end
    end

    nlits = {1'b0, cmd.lit0_v} + {1'b0, cmd.lit1_v};
    sum   = {1'b0, bw} + (CNT_BITS + 1)'(nlits)
            + (cmd.match_v ? (CNT_BITS + 1)'(cmd.len) : '0);
    bw_next = (sum > (CNT_BITS + 1)'(HIST_SIZE)) ? CNT_BITS'(HIST_SIZE) : sum[CNT_BITS-1:0];

    if (in_chan.end_of_input) begin
      cmd.done       = 1'b1;
      cmd.status     = err_next;
      phase_next     = PH_IDLE;
      held_lead_next = '0;
      held_dhi_next  = '0;
      err_next       = ST_OK;
      bw_next        = '0;
    end
  end

  assign push      = accept && (cmd.lit0_v || cmd.lit1_v || cmd.match_v || cmd.done);
  assign push_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      held_lead <= '0;
      held_dhi  <= '0;
      err       <= ST_OK;
      bw        <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      held_lead <= held_lead_next;
      held_dhi  <= held_dhi_next;
      err       <= err_next;
      bw        <= bw_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lzd_cmd_fifo.sv
// Small command queue between parser and copy engine.
// Depends on lzd_pkg.
`default_nettype none

module lzd_cmd_fifo
  import lzd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      full,
  output logic      empty
);

  cmd_t                   slots [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_BITS:0]   count;

  assign full     = (count == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/lzd_back.sv
// Copy engine: emits literals, copies matches from history, reports status.
// Depends on lzd_pkg and lzd_stream_if; holds the 64 KiB history memory.
`default_nettype none

module lzd_back
  import lzd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fifo_empty,
  input  cmd_t      head,
  output logic      pop,
  lzd_out_if.source out_chan
);

  back_state_t             state, state_next;
  cmd_t                    cur;
  logic [LEN_BITS-1:0]     cnt;
  logic [HISTORY_BITS-1:0] wp;
  logic [HISTORY_BITS-1:0] raddr;
  logic [7:0]              rdata;
  logic [7:0]              mem [HIST_SIZE];

  logic       out_valid;
  logic       can_load;
  logic       emit, emit_present, emit_last, emit_done, mem_we;
  logic [7:0] emit_byte;
  status_t    emit_status;

  assign can_load = !out_valid || out_chan.ready;
  assign pop      = (state == B_IDLE) && !fifo_empty;
  assign raddr    = wp - cur.distance;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (pop) state_next = B_EMIT;
      B_EMIT: begin
        if (cur.lit0_v || cur.lit1_v) begin
          if (can_load && emit_last) state_next = B_IDLE;
        end else if (cur.match_v) begin
          state_next = B_MRD;
        end else if (can_load) begin
          state_next = B_IDLE;
        end
      end
      B_MRD: state_next = B_MWR;
      B_MWR: begin
        if (can_load) begin
          if (cnt == LEN_BITS'(1)) state_next = cur.done ? B_EMIT : B_IDLE;
          else                     state_next = B_MRD;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit         = 1'b0;
    emit_byte    = '0;
    emit_present = 1'b0;
    emit_last    = 1'b0;
    emit_done    = 1'b0;
    emit_status  = ST_OK;
    mem_we       = 1'b0;
    unique case (state)
      B_EMIT: begin
        if (cur.lit0_v || cur.lit1_v) begin
          emit_byte    = cur.lit0_v ? cur.lit0 : cur.lit1;
          emit_present = 1'b1;
          emit_last    = !((cur.lit0_v && cur.lit1_v) || cur.match_v || cur.done);
          emit         = can_load;
          mem_we       = can_load;
        end else if (!cur.match_v) begin
          emit_done   = 1'b1;
          emit_status = cur.status;
          emit_last   = 1'b1;
          emit        = can_load;
        end
      end
      B_MWR: begin
        emit_byte    = rdata;
        emit_present = 1'b1;
        emit_last    = (cnt == LEN_BITS'(1)) && !cur.done;
        emit         = can_load;
        mem_we       = can_load;
      end
      default: ;
    endcase
  end

  // history memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wp] <= emit_byte;
    if (state == B_MRD) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      wp    <= '0;
    end else begin
      state <= state_next;
      if (mem_we) wp <= wp + 1'b1;
      else if (emit && emit_done) wp <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      cnt <= head.len;
    end else if (emit && state == B_EMIT && emit_present) begin
      if (cur.lit0_v) cur.lit0_v <= 1'b0;
      else            cur.lit1_v <= 1'b0;
    end else if (emit && state == B_MWR) begin
      cnt <= cnt - 1'b1;
      if (cnt == LEN_BITS'(1)) cur.match_v <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && emit) begin
      out_chan.out_byte     <= emit_byte;
      out_chan.byte_present <= emit_present;
      out_chan.run_last     <= emit_last;
      out_chan.stream_done  <= emit_done;
      out_chan.status       <= emit_status;
    end
  end

  assign out_chan.valid = out_valid;

endmodule

`default_nettype wire
